// ===== src/mf3_pkg.sv =====
// Shared types, constants and the nine-input median network for the 3x3 median filter.
// No dependencies; every module of the filter imports this package.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int PIX_W             = 8;
  localparam int FRAME_WIDTH_W     = 11;
  localparam int FRAME_HEIGHT_W    = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_INDEX_W       = 1;
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int WINDOW_SIZE       = 9;
  localparam int MEDIAN_RANK       = 5;

  localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = FRAME_WIDTH_W'(640);
  localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = FRAME_HEIGHT_W'(480);
  localparam logic [FRAME_HEIGHT_W-1:0] MIN_FRAME_HEIGHT   = FRAME_HEIGHT_W'(3);
  localparam int                        MIN_FRAME_WIDTH    = 3;

  typedef logic [PIX_W-1:0] pixel_t;

  // Entry 8 is the newest pixel, 7 the pixel one row up, 6 two rows up;
  // entries 0..5 are the two older columns.
  typedef pixel_t [WINDOW_SIZE-1:0] window_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Compare-exchange network of 19 steps; element 4 ends as the median.
  function automatic pixel_t median9(input window_t win);
    pixel_t p [WINDOW_SIZE];
    pixel_t t;
    int     a [19];
    int     b [19];
    a = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
    b = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      p[i] = win[i];
    end
    for (int s = 0; s < 19; s++) begin
      if (p[a[s]] > p[b[s]]) begin
        t       = p[a[s]];
        p[a[s]] = p[b[s]];
        p[b[s]] = t;
      end
    end
    return p[MEDIAN_RANK-1];
  endfunction

endpackage

// ===== src/mf3_line_buf.sv =====
// Two-row line store: one word per column holding the pixels one and two rows up.
// Uses mf3_pkg for the pixel width.
`timescale 1ns / 1ps

module mf3_line_buf #(
  parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [2*mf3_pkg::PIX_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [2*mf3_pkg::PIX_W-1:0] wr_data
);
  import mf3_pkg::*;

  // Low byte: row above. High byte: two rows above.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mf3_position.sv =====
// Column and row tracking of the raster stream, with the in-frame window check.
// Uses mf3_pkg for register widths and minimum frame sizes.
`timescale 1ns / 1ps

module mf3_position #(
  parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mf3_pkg::FRAME_WIDTH_W-1:0]   frame_width,
  input  logic [mf3_pkg::FRAME_HEIGHT_W-1:0]  frame_height,
  input  logic                                frame_start,
  input  logic                                advance,
  output logic [CW-1:0]                       col,
  output logic                                win_ok
);
  import mf3_pkg::*;

  localparam int CMPW = (CW + 1 > FRAME_WIDTH_W) ? CW + 1 : FRAME_WIDTH_W;
  localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MIN_W_C = CMPW'(MIN_FRAME_WIDTH);

  logic [CW-1:0]             column_count;
  logic [FRAME_HEIGHT_W-1:0] row_count;
  logic [FRAME_HEIGHT_W-1:0] row;
  logic [CMPW-1:0]           width_raw;
  logic [CMPW-1:0]           width_eff;
  logic [FRAME_HEIGHT_W-1:0] height_eff;
  logic [CMPW-1:0]           col_ext;
  logic [CMPW-1:0]           col_inc;
  logic [FRAME_HEIGHT_W:0]   row_inc;
  logic                      last_col;
  logic                      last_row;

  always_comb begin
    width_raw = CMPW'(frame_width);
    if (width_raw < MIN_W_C) begin
      width_eff = MIN_W_C;
    end else if (width_raw > MAX_W_C) begin
      width_eff = MAX_W_C;
    end else begin
      width_eff = width_raw;
    end
    height_eff = (frame_height < MIN_FRAME_HEIGHT) ? MIN_FRAME_HEIGHT : frame_height;

    col     = frame_start ? '0 : column_count;
    row     = frame_start ? '0 : row_count;
    col_ext = CMPW'(col);
    col_inc = col_ext + CMPW'(1);
    row_inc = {1'b0, row} + (FRAME_HEIGHT_W + 1)'(1);

    last_col = col_inc >= width_eff;
    last_row = row_inc >= {1'b0, height_eff};

    win_ok = (row >= FRAME_HEIGHT_W'(2)) && (col_ext >= CMPW'(2)) &&
             (row < height_eff) && (col_ext < width_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_inc[FRAME_HEIGHT_W-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
        row_count    <= row;
      end
    end
  end

endmodule

// ===== src/mf3_median.sv =====
// Result register: the median of a full 3x3 window, forced to zero outside the frame.
// Uses mf3_pkg for the window type and the median network.
`timescale 1ns / 1ps

module mf3_median (
  input  logic                clk,
  input  logic                load,
  input  mf3_pkg::window_t    window,
  input  logic                win_ok,
  output mf3_pkg::pixel_t     median_value,
  output logic                window_valid
);
  import mf3_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      median_value <= win_ok ? median9(window) : '0;
      window_valid <= win_ok;
    end
  end

endmodule

// ===== src/median_filter_3x3.sv =====
// 3x3 median filter over a raster stream of 8-bit grayscale pixels, one result per pixel.
// Results pass through the read, window and median registers in that order before m_tvalid
// rises. Throughput: one pixel per clock unless m_tready stalls the result stream; the line
// store takes one read and one write per cycle.
// Reset (rst, synchronous, active high) clears counters, window and pipeline valids and
// loads frame_width 640 and frame_height 480; the line store is not cleared.
// Depends on mf3_pkg, mf3_line_buf, mf3_position and mf3_median.
`timescale 1ns / 1ps

module median_filter_3x3 #(
  parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // Pixel input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mf3_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel_value
  input  logic                               s_tuser,   // [0] frame_start
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mf3_pkg::PIX_W-1:0]          m_tdata,   // [7:0] median_value
  output logic                               m_tuser,   // [0] window_valid
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mf3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers. Writes are always taken.
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage moves on when the next one is empty or moving,
  // so bubbles collapse and a waiting result blocks a new input transaction only once
  // both pipeline stages behind it are full as well.
  logic s1_valid;
  logic s2_valid;
  logic out_take;
  logic s2_move;
  logic s2_take;
  logic s1_move;
  logic in_accept;

  assign out_take  = !m_tvalid || m_tready;
  assign s2_move   = s2_valid && out_take;
  assign s2_take   = !s2_valid || out_take;
  assign s1_move   = s1_valid && s2_take;
  assign s_tready  = !s1_valid || s2_take;
  assign in_accept = s_tvalid && s_tready;

  // Stage 0: position of the incoming pixel and the line store read at its column.
  logic [CW-1:0] col_cur;
  logic          win_ok_cur;

  mf3_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_start  (s_tuser),
    .advance      (in_accept),
    .col          (col_cur),
    .win_ok       (win_ok_cur)
  );

  logic [2*PIX_W-1:0] line_rd;
  logic [2*PIX_W-1:0] line_wr;

  // Stage 1 registers.
  pixel_t             s1_pix;
  logic [CW-1:0]      s1_col;
  logic               s1_win_ok;
  logic               s1_fwd;
  logic [2*PIX_W-1:0] s1_fwd_data;

  logic [2*PIX_W-1:0] s1_line;
  pixel_t             s1_mid;
  pixel_t             s1_top;

  // A restart at the column that stage 1 is writing in the same cycle would read the
  // stale word, so the fresh word is carried along and used instead.
  assign s1_line = s1_fwd ? s1_fwd_data : line_rd;
  assign s1_mid  = s1_line[PIX_W-1:0];
  assign s1_top  = s1_line[2*PIX_W-1:PIX_W];
  assign line_wr = {s1_mid, s1_pix};

  mf3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_cur),
    .rd_data (line_rd),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data (line_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix      <= s_tdata;
      s1_col      <= col_cur;
      s1_win_ok   <= win_ok_cur;
      s1_fwd      <= s1_move && (s1_col == col_cur);
      s1_fwd_data <= line_wr;
    end
  end

  // Stage 1: assemble the window from the two stored columns and the new column.
  pixel_t  window_regs [6];
  window_t win_cur;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_cur[k] = window_regs[k];
    end
    win_cur[6] = s1_top;
    win_cur[7] = s1_mid;
    win_cur[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        window_regs[k] <= '0;
      end
    end else if (s1_move) begin
      for (int k = 0; k < 3; k++) begin
        window_regs[k] <= window_regs[k+3];
      end
      window_regs[3] <= s1_top;
      window_regs[4] <= s1_mid;
      window_regs[5] <= s1_pix;
    end
  end

  // Stage 2 registers: the complete window and its in-frame flag.
  window_t s2_window;
  logic    s2_win_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_window <= win_cur;
      s2_win_ok <= s1_win_ok;
    end
  end

  // Stage 2 to output: median network into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_take) begin
      m_tvalid <= s2_valid;
    end
  end

  mf3_median u_median (
    .clk          (clk),
    .load         (s2_move),
    .window       (s2_window),
    .win_ok       (s2_win_ok),
    .median_value (m_tdata),
    .window_valid (m_tuser)
  );

endmodule

// ===== tb/median_filter_3x3_tb.sv =====
// Self-checking testbench for the 3x3 median filter: streams pixel frames of many sizes,
// predicts every median with its own line store and window, and checks each result.
// Depends on mf3_pkg and median_filter_3x3 only.
`timescale 1ns / 1ps

module median_filter_3x3_tb;
  import mf3_pkg::*;

  localparam int LINE_LEN    = DEFAULT_MAX_WIDTH;
  localparam int MAX_REPORTS = 10;

  // One pixel waiting to be sent, with its start-of-frame mark.
  typedef struct {
    pixel_t pix;
    logic   sof;
  } pixel_item_t;

  // One expected result transaction.
  typedef struct {
    pixel_t median_value;
    logic   window_valid;
  } median_result_t;

  // How the pixel content of a run is drawn.
  typedef enum int {
    CONTENT_UNIFORM,
    CONTENT_IMPULSE,
    CONTENT_LEVELS
  } content_t;

  // Patterns the result receiver cycles through.
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_PERIODIC,
    RDY_LONG_STALL
  } ready_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  median_filter_3x3 #(
    .MAX_WIDTH(LINE_LEN)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter prediction. The testbench keeps its own copy of both line banks, the
  // two older window columns, the raster position and the register values.
  // ---------------------------------------------------------------------------
  bit [PIX_W-1:0] line_mem [2*LINE_LEN];  // bank 0: row above, bank 1: two rows above
  bit [PIX_W-1:0] win_cols [6];           // two older window columns, oldest first
  int unsigned    col_pos    = 0;
  int unsigned    row_pos    = 0;
  int unsigned    cur_width  = RESET_FRAME_WIDTH;
  int unsigned    cur_height = RESET_FRAME_HEIGHT;

  pixel_item_t    pending_pixels   [$];
  median_result_t expected_medians [$];
  int             medians_owed     = 0;  // queued pixels whose result has not arrived

  int unsigned pixels_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned windows_seen   = 0;
  int unsigned writes_done    = 0;
  int unsigned error_count    = 0;

  // Row length actually used: the register clamped into the line store.
  function automatic int unsigned eff_width();
    if (cur_width < MIN_FRAME_WIDTH) return MIN_FRAME_WIDTH;
    if (cur_width > LINE_LEN) return LINE_LEN;
    return cur_width;
  endfunction

  // Work out the result of one accepted pixel and append it to the expected store.
  task automatic predict_median(input pixel_t pix, input logic sof);
    int unsigned    w, h, c, r;
    int             j;
    pixel_t         top, mid, t;
    pixel_t         vals [9];
    median_result_t res;
    w = eff_width();
    h = (cur_height < MIN_FRAME_HEIGHT) ? MIN_FRAME_HEIGHT : cur_height;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;

    // The column of the window that ends here: two rows up, one row up, this pixel.
    mid = line_mem[c];
    top = line_mem[LINE_LEN + c];
    line_mem[LINE_LEN + c] = mid;
    line_mem[c]            = pix;

    for (int k = 0; k < 6; k++) vals[k] = win_cols[k];
    vals[6] = top;
    vals[7] = mid;
    vals[8] = pix;
    for (int k = 0; k < 3; k++) win_cols[k] = win_cols[k + 3];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = pix;

    // Plain insertion sort; the middle entry is the median.
    for (int i = 1; i < WINDOW_SIZE; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end

    // A position left beyond a size that shrank gives no window until it wraps.
    res.window_valid = (r >= 2 && c >= 2 && r < h && c < w);
    res.median_value = res.window_valid ? vals[MEDIAN_RANK-1] : '0;
    expected_medians.push_back(res);

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver. It sends in bursts of random length separated by random gaps,
  // and predicts the result of each pixel at the edge where its transaction
  // completes. A burst left with no gap gives long stretches at full rate.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_pixels
    pixel_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_median(s_tdata, s_tuser);
        pixels_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          nxt = pending_pixels.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.pix;
          s_tuser  <= nxt.sof;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 47);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. The ready pattern is redrawn at random among always ready, coin flips,
  // rare stalls, a short periodic stall and long periodic stalls, so back-pressure lands on
  // every stage of the pipeline.
  // ---------------------------------------------------------------------------
  ready_mode_t rdy_mode  = RDY_ALWAYS;
  int          mode_left = 0;
  int unsigned ticks     = 0;

  always @(posedge clk) begin : pace_receiver
    if (mode_left == 0) begin
      rdy_mode  = ready_mode_t'($urandom_range(0, 4));
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    ticks++;
    case (rdy_mode)
      RDY_ALWAYS:     m_tready <= 1'b1;
      RDY_COIN:       m_tready <= 1'($urandom_range(0, 1));
      RDY_MOSTLY:     m_tready <= ($urandom_range(0, 7) != 0);
      RDY_PERIODIC:   m_tready <= ((ticks % 11) > 3);
      RDY_LONG_STALL: m_tready <= ((ticks % 64) < 34);
      default:        m_tready <= 1'b1;
    endcase
  end

  // Every result transaction is matched against the oldest expected result.
  always @(posedge clk) begin : check_medians
    median_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_medians.size() == 0) begin
        note_error($sformatf("result with nothing expected: median %0d, valid %0b",
                             m_tdata, m_tuser));
      end else begin
        want = expected_medians.pop_front();
        medians_owed--;
        results_seen++;
        if (m_tuser === 1'b1) windows_seen++;
        if (m_tuser !== want.window_valid)
          note_error($sformatf("result %0d: window_valid expected %0b, got %0b",
                               results_seen, want.window_valid, m_tuser));
        if (m_tdata !== want.median_value)
          note_error($sformatf("result %0d: median_value expected %0d, got %0d",
                               results_seen, want.median_value, m_tdata));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. They are called at a rising edge.
  // ---------------------------------------------------------------------------

  // Waits until every queued pixel has produced its result; the block is idle then.
  task automatic wait_drained();
    while (medians_owed != 0) @(posedge clk);
  endtask

  // A register write transaction; the predictor takes the value at the handshake.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) cur_width = value[FRAME_WIDTH_W-1:0];
    else cur_height = value;
    writes_done++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes both sizes in a random order.
  task automatic apply_size(input logic [CFG_DATA_W-1:0] w_data,
                            input logic [CFG_DATA_W-1:0] h_data);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_FRAME_WIDTH, w_data);
      write_reg(REG_FRAME_HEIGHT, h_data);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h_data);
      write_reg(REG_FRAME_WIDTH, w_data);
    end
  endtask

  task automatic queue_pixel(input pixel_t pix, input logic sof);
    pixel_item_t it;
    it.pix = pix;
    it.sof = sof;
    pending_pixels.push_back(it);
    medians_owed++;
  endtask

  // Impulse content is a flat level with salt-and-pepper spikes, the case the
  // filter exists for; level content draws from three values to force ties.
  function automatic pixel_t next_pixel(input content_t content, input pixel_t base);
    int v;
    case (content)
      CONTENT_IMPULSE: begin
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        v = int'(base) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pixel_t'(v);
      end
      CONTENT_LEVELS: begin
        case ($urandom_range(0, 2))
          0:       return 8'h00;
          1:       return 8'hFF;
          default: return base;
        endcase
      end
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // Queues a run of pixels and waits for all its results. A run that restarts
  // marks its first pixel as a frame start; stray starts may also fall mid-frame.
  task automatic queue_run(input int count, input logic restart, input logic stray_starts,
                           input content_t content, input logic pause_midway);
    pixel_t base;
    logic   sof;
    base = pixel_t'($urandom);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_drained();
      sof = (i == 0) ? restart : (stray_starts && $urandom_range(0, 150) == 0);
      queue_pixel(next_pixel(content, base), sof);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : run_stimulus
    pixel_t      corner_frames [18];
    int unsigned random_items;
    int unsigned w_pick, h_pick, count;
    logic        keep_going;

    corner_frames = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                      8'hFF, 8'h00, 8'hFF,
                      8'd10, 8'd200, 8'd30, 8'd40, 8'd250, 8'd60,
                      8'd70, 8'd80, 8'd90};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes of 640x480: a few pixels, none of them completes a window.
    queue_run(8, 1'b1, 1'b0, CONTENT_UNIFORM, 1'b0);

    // Smallest frame, two frames back to back. The second follows the wrap at the
    // end of the first with no start mark. The sender waits for all results
    // between the two frames.
    apply_size(16'd3, 16'd3);
    for (int k = 0; k < 18; k++) begin
      if (k == 9) wait_drained();
      queue_pixel(corner_frames[k], k == 0);
    end
    wait_drained();

    random_items = 0;

    // Clamped sizes: width and height fields below three, stray upper bits in the
    // width write, and the tallest height on the narrowest row.
    apply_size(16'hF801, 16'd0);
    queue_run(30, 1'b1, 1'b0, CONTENT_UNIFORM, 1'b0);
    apply_size(16'd2, 16'd2);
    queue_run(25, 1'b1, 1'b0, CONTENT_LEVELS, 1'b0);
    apply_size(16'd3, 16'hFFFF);
    queue_run(40, 1'b1, 1'b0, CONTENT_IMPULSE, 1'b0);
    apply_size(16'd5, 16'd1);
    queue_run(35, 1'b1, 1'b0, CONTENT_UNIFORM, 1'b1);
    random_items += 130;

    // Random frame sizes, mostly small so that many rows and frames wrap.
    while (random_items < 800) begin
      keep_going = (random_items > 130) && ($urandom_range(0, 4) == 0);
      if (!keep_going) begin
        case ($urandom_range(0, 9))
          0:       w_pick = $urandom_range(0, 2);
          8:       w_pick = $urandom_range(21, 64);
          9:       w_pick = 3;
          default: w_pick = $urandom_range(3, 20);
        endcase
        case ($urandom_range(0, 9))
          0:       h_pick = $urandom_range(0, 2);
          7:       h_pick = 16'hFFFF;
          8:       h_pick = $urandom_range(9, 300);
          9:       h_pick = 3;
          default: h_pick = $urandom_range(3, 8);
        endcase
        // Bits above the width field are noise the block must ignore.
        if ($urandom_range(0, 3) == 0)
          write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(w_pick)});
        else
          apply_size({5'($urandom), 11'(w_pick)}, 16'(h_pick));
      end
      count = eff_width() * $urandom_range(3, 6) + $urandom_range(0, eff_width() - 1);
      queue_run(count, !keep_going, 1'b1, content_t'($urandom_range(0, 2)),
                $urandom_range(0, 3) == 0);
      random_items += count;
    end

    // Sizes shrunk in the middle of a frame: first the width while the column is
    // past the new row end, then the height while the row is past the new last row.
    apply_size(16'd16, 16'd10);
    queue_run(74, 1'b1, 1'b0, CONTENT_IMPULSE, 1'b0);
    write_reg(REG_FRAME_WIDTH, 16'd8);
    queue_run(30, 1'b0, 1'b0, CONTENT_UNIFORM, 1'b0);
    write_reg(REG_FRAME_HEIGHT, 16'd4);
    queue_run(40, 1'b0, 1'b0, CONTENT_UNIFORM, 1'b0);

    // Widest rows: an all-ones width field clamps to the full line store, and the
    // start of such a row must stream through with no window.
    apply_size(16'hFFFF, 16'hFFFF);
    queue_run(40, 1'b1, 1'b0, CONTENT_IMPULSE, 1'b0);
    apply_size(16'(LINE_LEN), 16'd3);
    queue_run(40, 1'b1, 1'b0, CONTENT_UNIFORM, 1'b0);

    // Let the pipeline run dry; anything arriving now has no expectation.
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Run covered %0d pixels and %0d checked results, %0d of them full windows.",
             pixels_sent, results_seen, windows_seen);
    $display("Frame sizes changed %0d times, from clamped minimums to %0d-pixel rows.",
             writes_done, LINE_LEN);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total.", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin : watchdog
    #6_000_000;
    $display("Timeout with %0d results still outstanding.", medians_owed);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
